// File: rtl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// RC4 package
// Shared constants, sequencer states and the structs that pass between the
// modules of the RC4 engine.
// ----------------------------------------------------------------------------
package rc4_pkg;

  // The permutation table always has one entry per byte value.
  localparam int unsigned TABLE_SIZE    = 256;
  localparam int unsigned IDX_W         = 8;
  localparam int unsigned MAX_KEY_BYTES = 256;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KS_RD,
    ST_KS_ADD,
    ST_KS_WR_N,
    ST_KS_WR_J,
    ST_GEN_I,
    ST_GEN_J,
    ST_GEN_SWAP,
    ST_GEN_OUT
  } state_e;

  // One write port and one read port of the permutation table.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } sbox_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] keystream_byte;
  } res_t;

endpackage

// File: rtl/rc4_if.sv
// ----------------------------------------------------------------------------
// RC4 channel interfaces
// Valid/ready channels for input requests and for results.
// ----------------------------------------------------------------------------
interface rc4_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] value;
  logic       key_last;

  modport source (output valid, kind, value, key_last, input ready);
  modport sink   (input valid, kind, value, key_last, output ready);
endinterface

interface rc4_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [7:0] keystream_byte;

  modport source (output valid, out_byte, keystream_byte, input ready);
  modport sink   (input valid, out_byte, keystream_byte, output ready);
endinterface

// File: rtl/rc4_add.sv
// ----------------------------------------------------------------------------
// RC4 shared adder
// Three-operand modulo-256 adder used for the i, j and t index calculations.
// ----------------------------------------------------------------------------
module rc4_add (
  input  logic [rc4_pkg::IDX_W-1:0] a_i,
  input  logic [rc4_pkg::IDX_W-1:0] b_i,
  input  logic [rc4_pkg::IDX_W-1:0] c_i,
  output logic [rc4_pkg::IDX_W-1:0] sum_o
);

  // The carry out is dropped, which gives the wrap at the table size.
  assign sum_o = a_i + b_i + c_i;

endmodule

// File: rtl/rc4_sbox.sv
// ----------------------------------------------------------------------------
// RC4 permutation table
// 256-entry memory with registered read; entries never written read as zero.
// ----------------------------------------------------------------------------
module rc4_sbox (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rc4_pkg::sbox_req_t        req_i,
  output logic [rc4_pkg::IDX_W-1:0] rdata_o
);

  logic [rc4_pkg::IDX_W-1:0]      mem_q [rc4_pkg::TABLE_SIZE];
  logic [rc4_pkg::TABLE_SIZE-1:0] valid_q;
  logic [rc4_pkg::IDX_W-1:0]      rd_q;
  logic                           rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem_q[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvld_q <= valid_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rvld_q ? rd_q : '0;

endmodule

// File: rtl/rc4_keymem.sv
// ----------------------------------------------------------------------------
// RC4 key store
// Key byte memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rc4_keymem #(
  parameter int unsigned MaxKeyBytes = rc4_pkg::MAX_KEY_BYTES,
  localparam int unsigned Aw = (MaxKeyBytes > 1) ? $clog2(MaxKeyBytes) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [MaxKeyBytes];
  logic [7:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rd_q;

endmodule

// File: rtl/rc4_core.sv
// ----------------------------------------------------------------------------
// RC4 sequencer
// Steps the key schedule and the keystream generator through the shared
// adder and the permutation table with its one read port and one write port.
// ----------------------------------------------------------------------------
module rc4_core #(
  parameter int unsigned MaxKeyBytes = rc4_pkg::MAX_KEY_BYTES,
  localparam int unsigned Kaw = (MaxKeyBytes > 1) ? $clog2(MaxKeyBytes) : 1,
  localparam int unsigned Klw = $clog2(MaxKeyBytes + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      in_kind_i,
  input  logic [7:0]                in_value_i,
  input  logic                      in_last_i,
  input  logic                      out_free_i,
  output logic                      res_load_o,
  output rc4_pkg::res_t             res_o,
  output rc4_pkg::sbox_req_t        sbox_req_o,
  input  logic [rc4_pkg::IDX_W-1:0] sbox_rdata_i,
  output logic                      key_we_o,
  output logic [Kaw-1:0]            key_waddr_o,
  output logic [7:0]                key_wdata_o,
  output logic                      key_re_o,
  output logic [Kaw-1:0]            key_raddr_o,
  input  logic [7:0]                key_rdata_i
);

  localparam int unsigned W = rc4_pkg::IDX_W;

  rc4_pkg::state_e state_q, state_d;
  logic [W-1:0]   i_q, i_d, j_q, j_d, n_q, n_d;
  logic [W-1:0]   si_q, si_d, sj_q, sj_d, t_q, t_d, val_q, val_d;
  logic [Kaw-1:0] k_q, k_d;
  logic [Klw-1:0] klen_q, klen_d;
  logic [W-1:0]   add_a, add_b, add_c, add_s;
  logic [Kaw:0]   k_inc;
  logic           k_wrap;
  logic           accept;
  logic [W-1:0]   ks;

  rc4_add u_add (
    .a_i   (add_a),
    .b_i   (add_b),
    .c_i   (add_c),
    .sum_o (add_s)
  );

  assign in_ready_o = (state_q == rc4_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // The key index wraps at the key length.
  assign k_inc  = {1'b0, k_q} + (Kaw + 1)'(1);
  assign k_wrap = (k_inc >= (Kaw + 1)'(klen_q));

  // After the swap S[i] holds the old S[j] and S[j] the old S[i], so a
  // keystream address that hits either index is taken from the registers.
  always_comb begin
    if (t_q == j_q) begin
      ks = si_q;
    end else if (t_q == i_q) begin
      ks = sj_q;
    end else begin
      ks = sbox_rdata_i;
    end
  end

  assign res_o.keystream_byte = ks;
  assign res_o.out_byte       = val_q ^ ks;

  always_comb begin
    state_d = state_q;
    case (state_q)
      rc4_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_kind_i) begin
            state_d = rc4_pkg::ST_GEN_I;
          end else if (in_last_i) begin
            state_d = rc4_pkg::ST_FILL;
          end
        end
      end
      rc4_pkg::ST_FILL: begin
        if (n_q == '1) begin
          state_d = rc4_pkg::ST_KS_RD;
        end
      end
      rc4_pkg::ST_KS_RD:    state_d = rc4_pkg::ST_KS_ADD;
      rc4_pkg::ST_KS_ADD:   state_d = rc4_pkg::ST_KS_WR_N;
      rc4_pkg::ST_KS_WR_N:  state_d = rc4_pkg::ST_KS_WR_J;
      rc4_pkg::ST_KS_WR_J: begin
        state_d = (n_q == '1) ? rc4_pkg::ST_IDLE : rc4_pkg::ST_KS_RD;
      end
      rc4_pkg::ST_GEN_I:    state_d = rc4_pkg::ST_GEN_J;
      rc4_pkg::ST_GEN_J:    state_d = rc4_pkg::ST_GEN_SWAP;
      rc4_pkg::ST_GEN_SWAP: state_d = rc4_pkg::ST_GEN_OUT;
      rc4_pkg::ST_GEN_OUT: begin
        if (out_free_i) begin
          state_d = rc4_pkg::ST_IDLE;
        end
      end
      default:              state_d = rc4_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    i_d         = i_q;
    j_d         = j_q;
    n_d         = n_q;
    k_d         = k_q;
    klen_d      = klen_q;
    si_d        = si_q;
    sj_d        = sj_q;
    t_d         = t_q;
    val_d       = val_q;
    add_a       = '0;
    add_b       = '0;
    add_c       = '0;
    sbox_req_o  = '0;
    key_we_o    = 1'b0;
    key_waddr_o = klen_q[Kaw-1:0];
    key_wdata_o = in_value_i;
    key_re_o    = 1'b0;
    key_raddr_o = k_q;
    res_load_o  = 1'b0;
    case (state_q)
      rc4_pkg::ST_IDLE: begin
        if (accept) begin
          val_d = in_value_i;
          if (!in_kind_i) begin
            // Bytes beyond the key store are dropped and not counted.
            if (klen_q < Klw'(MaxKeyBytes)) begin
              key_we_o = 1'b1;
              klen_d   = klen_q + Klw'(1);
            end
            if (in_last_i) begin
              n_d = '0;
              j_d = '0;
              k_d = '0;
            end
          end
        end
      end
      rc4_pkg::ST_FILL: begin
        sbox_req_o.we    = 1'b1;
        sbox_req_o.waddr = n_q;
        sbox_req_o.wdata = n_q;
        n_d              = n_q + W'(1);
      end
      rc4_pkg::ST_KS_RD: begin
        sbox_req_o.re    = 1'b1;
        sbox_req_o.raddr = n_q;
        key_re_o         = 1'b1;
      end
      rc4_pkg::ST_KS_ADD: begin
        add_a            = j_q;
        add_b            = sbox_rdata_i;
        add_c            = key_rdata_i;
        j_d              = add_s;
        si_d             = sbox_rdata_i;
        sbox_req_o.re    = 1'b1;
        sbox_req_o.raddr = add_s;
      end
      rc4_pkg::ST_KS_WR_N: begin
        sbox_req_o.we    = 1'b1;
        sbox_req_o.waddr = n_q;
        sbox_req_o.wdata = sbox_rdata_i;
      end
      rc4_pkg::ST_KS_WR_J: begin
        sbox_req_o.we    = 1'b1;
        sbox_req_o.waddr = j_q;
        sbox_req_o.wdata = si_q;
        n_d              = n_q + W'(1);
        k_d              = k_wrap ? '0 : k_inc[Kaw-1:0];
        if (n_q == '1) begin
          i_d    = '0;
          j_d    = '0;
          klen_d = '0;
        end
      end
      rc4_pkg::ST_GEN_I: begin
        add_a            = i_q;
        add_b            = W'(1);
        i_d              = add_s;
        sbox_req_o.re    = 1'b1;
        sbox_req_o.raddr = add_s;
      end
      rc4_pkg::ST_GEN_J: begin
        add_a            = j_q;
        add_b            = sbox_rdata_i;
        j_d              = add_s;
        si_d             = sbox_rdata_i;
        sbox_req_o.re    = 1'b1;
        sbox_req_o.raddr = add_s;
      end
      rc4_pkg::ST_GEN_SWAP: begin
        sj_d             = sbox_rdata_i;
        sbox_req_o.we    = 1'b1;
        sbox_req_o.waddr = i_q;
        sbox_req_o.wdata = sbox_rdata_i;
        add_a            = si_q;
        add_b            = sbox_rdata_i;
        t_d              = add_s;
        sbox_req_o.re    = 1'b1;
        sbox_req_o.raddr = add_s;
      end
      rc4_pkg::ST_GEN_OUT: begin
        // Rewriting the same entry while the result waits is harmless.
        sbox_req_o.we    = 1'b1;
        sbox_req_o.waddr = j_q;
        sbox_req_o.wdata = si_q;
        res_load_o       = out_free_i;
      end
      default: begin
        res_load_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rc4_pkg::ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      n_q     <= '0;
      k_q     <= '0;
      klen_q  <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      n_q     <= n_d;
      k_q     <= k_d;
      klen_q  <= klen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    si_q  <= si_d;
    sj_q  <= sj_d;
    t_q   <= t_d;
    val_q <= val_d;
  end

  a_fill_has_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rc4_pkg::ST_FILL) |-> (klen_q != '0))
    else $error("key schedule started with an empty key");

  a_gen_from_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rc4_pkg::ST_GEN_I) |-> $past(in_valid_i && in_ready_o && in_kind_i))
    else $error("generator step without an accepted data request");

  a_sched_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rc4_pkg::ST_KS_WR_J && n_q == '1) |=>
      (state_q == rc4_pkg::ST_IDLE && i_q == '0 && j_q == '0 && klen_q == '0))
    else $error("indices or key length not cleared after key schedule");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rc4_pkg::ST_GEN_OUT && !out_free_i) |=>
      (state_q == rc4_pkg::ST_GEN_OUT && $stable(t_q) && $stable(si_q) && $stable(sj_q)))
    else $error("pending keystream result lost while output stalled");

endmodule

// File: rtl/rc4_stream_cipher.sv
// ----------------------------------------------------------------------------
// RC4 stream cipher
// Key loading, key schedule and keystream generation over one shared table.
// ----------------------------------------------------------------------------
// Requests arrive on in_i. A request with kind low is a key byte and is
// stored in the key store; bytes beyond MaxKeyBytes are dropped. A key byte
// with key_last high closes the key: the table is loaded with the identity
// and the key schedule steps each entry through a read of S[n] and the key
// byte, an add with a read of S[j], and the writes of S[n] and S[j]; no
// request is taken until it ends. Other key bytes give no result.
// A request with kind high is a data byte. It advances the generator by one
// step and yields one result on out_o: the data byte XOR the keystream byte,
// and the keystream byte itself. The result becomes valid in the same cycle
// that in_i is ready again, so a data byte is taken only once the one before
// has loaded its result. The pace is set by the single read port of the
// table: reads of S[i], S[j] and S[t] plus the swap writes.
// Results sit in an output register, so key bytes are still accepted while a
// result waits; a data byte whose result finds the register full holds its
// last step until out_o is taken, and in_i.ready stays low meanwhile.
// After reset the table reads as all zeros, so until a key has been loaded
// the keystream is zero and data passes through unchanged.
// ----------------------------------------------------------------------------
module rc4_stream_cipher #(
  parameter int unsigned MaxKeyBytes = rc4_pkg::MAX_KEY_BYTES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rc4_in_if.sink    in_i,
  rc4_out_if.source out_o
);

  localparam int unsigned Kaw = (MaxKeyBytes > 1) ? $clog2(MaxKeyBytes) : 1;

  rc4_pkg::sbox_req_t        sbox_req;
  logic [rc4_pkg::IDX_W-1:0] sbox_rdata;
  logic                      key_we;
  logic [Kaw-1:0]            key_waddr;
  logic [7:0]                key_wdata;
  logic                      key_re;
  logic [Kaw-1:0]            key_raddr;
  logic [7:0]                key_rdata;
  logic                      out_free;
  logic                      res_load;
  rc4_pkg::res_t             res;
  rc4_pkg::res_t             out_res_q;
  logic                      out_vld_q, out_vld_d;

  // The permutation table; all of its traffic comes from the sequencer.
  rc4_sbox u_sbox (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (sbox_req),
    .rdata_o (sbox_rdata)
  );

  // The key store is written as key bytes arrive and read by the schedule.
  rc4_keymem #(
    .MaxKeyBytes (MaxKeyBytes)
  ) u_keymem (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .re_i    (key_re),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  rc4_core #(
    .MaxKeyBytes (MaxKeyBytes)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_kind_i    (in_i.kind),
    .in_value_i   (in_i.value),
    .in_last_i    (in_i.key_last),
    .out_free_i   (out_free),
    .res_load_o   (res_load),
    .res_o        (res),
    .sbox_req_o   (sbox_req),
    .sbox_rdata_i (sbox_rdata),
    .key_we_o     (key_we),
    .key_waddr_o  (key_waddr),
    .key_wdata_o  (key_wdata),
    .key_re_o     (key_re),
    .key_raddr_o  (key_raddr),
    .key_rdata_i  (key_rdata)
  );

  // The output register is free when it is empty or being emptied now.
  assign out_free  = !out_vld_q || out_o.ready;
  assign out_vld_d = res_load || (out_vld_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.out_byte       = out_res_q.out_byte;
  assign out_o.keystream_byte = out_res_q.keystream_byte;

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// RC4 stream cipher testbench
// Streams key and data requests into the engine and keeps a shadow copy of
// the permutation table, key store and generator indices. Every data request
// produces one predicted result, and each result taken from the engine is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------

typedef enum logic {
  REQ_KEY  = 1'b0,
  REQ_DATA = 1'b1
} req_kind_e;

// Shadow of the cipher state, plus the queue of results still owed.
class rc4_shadow_cipher;
  logic [7:0]    sbox [rc4_pkg::TABLE_SIZE];
  logic [7:0]    key_bytes [rc4_pkg::MAX_KEY_BYTES];
  int unsigned   key_count;
  logic [7:0]    gen_i;
  logic [7:0]    gen_j;
  rc4_pkg::res_t expected_q [$];
  int unsigned   mismatches;

  function new();
    foreach (sbox[n]) sbox[n] = '0;
    foreach (key_bytes[n]) key_bytes[n] = '0;
    key_count  = 0;
    gen_i      = '0;
    gen_j      = '0;
    mismatches = 0;
  endfunction

  function void flag(string what);
    mismatches++;
    if (mismatches <= 10) $display("Mismatch: %s", what);
  endfunction

  // Identity load followed by the key schedule; the key index wraps at the
  // number of bytes collected for this key.
  function void load_key();
    logic [7:0] j;
    logic [7:0] tmp;
    j = '0;
    for (int n = 0; n < rc4_pkg::TABLE_SIZE; n++) sbox[n] = 8'(n);
    for (int n = 0; n < rc4_pkg::TABLE_SIZE; n++) begin
      j       = j + sbox[n] + key_bytes[n % key_count];
      tmp     = sbox[n];
      sbox[n] = sbox[j];
      sbox[j] = tmp;
    end
    gen_i     = '0;
    gen_j     = '0;
    key_count = 0;
  endfunction

  function void take_request(logic kind, logic [7:0] value, logic last);
    rc4_pkg::res_t res;
    logic [7:0]    tmp;
    logic [7:0]    t_idx;
    if (kind == REQ_KEY) begin
      // Bytes beyond the store are dropped but a final one still closes it.
      if (key_count < rc4_pkg::MAX_KEY_BYTES) begin
        key_bytes[key_count] = value;
        key_count++;
      end
      if (last) load_key();
    end else begin
      gen_i              = gen_i + 8'd1;
      gen_j              = gen_j + sbox[gen_i];
      tmp                = sbox[gen_i];
      sbox[gen_i]        = sbox[gen_j];
      sbox[gen_j]        = tmp;
      t_idx              = sbox[gen_i] + sbox[gen_j];
      res.keystream_byte = sbox[t_idx];
      res.out_byte       = value ^ res.keystream_byte;
      expected_q.push_back(res);
    end
  endfunction

  function void check_result(logic [7:0] out_byte, logic [7:0] ks_byte);
    rc4_pkg::res_t want;
    if (expected_q.size() == 0) begin
      flag($sformatf("unexpected result out_byte=%02h keystream_byte=%02h",
                     out_byte, ks_byte));
    end else begin
      want = expected_q.pop_front();
      if (out_byte !== want.out_byte)
        flag($sformatf("out_byte expected %02h got %02h", want.out_byte, out_byte));
      if (ks_byte !== want.keystream_byte)
        flag($sformatf("keystream_byte expected %02h got %02h",
                       want.keystream_byte, ks_byte));
    end
  endfunction
endclass

module tb_top;

  localparam int unsigned TOTAL_ITEMS   = 1350;
  // A closing key byte keeps the engine busy through the whole key schedule,
  // during which no request is taken; the limit allows several times that long.
  localparam int unsigned STALL_LIMIT   = 8000;
  // Quiet time after the last result, long enough for a full key schedule.
  localparam int unsigned SETTLE_CYCLES = 1300;

  logic clk_i;
  logic rst_ni;

  rc4_in_if  req_ch ();
  rc4_out_if res_ch ();

  rc4_shadow_cipher shadow = new();

  int unsigned items_sent = 0;
  // Once set, neither side idles any more, for the closing stretch of the run.
  bit          calm = 1'b0;

  rc4_stream_cipher DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (res_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Both channels are sampled in the active region straight after the rising
  // edge, so the values seen are the ones that were present at the edge.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        shadow.check_result(res_ch.out_byte, res_ch.keystream_byte);
      if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
        shadow.take_request(req_ch.kind, req_ch.value, req_ch.key_last);
    end
  end

  // The watchdog ends the run if neither channel moves for too long.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  // The result side drops ready in bursts, with quiet stretches in between.
  initial begin
    res_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 9) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
    end
  end

  // Presents one request and holds it until the engine takes it. Called at a
  // rising edge; returns at the edge where the request was accepted, so the
  // next call can keep valid high without a gap.
  task automatic send_request(input req_kind_e kind, input logic [7:0] value,
                              input logic last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    req_ch.valid    <= 1'b1;
    req_ch.kind     <= kind;
    req_ch.value    <= value;
    req_ch.key_last <= last;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    items_sent++;
    if (items_sent >= TOTAL_ITEMS * 9 / 10) calm = 1'b1;
  endtask

  task automatic send_key(input int unsigned len);
    for (int unsigned n = 0; n < len; n++)
      send_request(REQ_KEY, 8'($urandom), n == len - 1);
  endtask

  // Data requests now and then carry key_last, which the engine must ignore.
  task automatic send_data(input int unsigned count);
    repeat (count)
      send_request(REQ_DATA, 8'($urandom), $urandom_range(0, 7) == 0);
  endtask

  // Holds the request side idle until every predicted result has been taken.
  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (shadow.expected_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned key_len;
    int unsigned data_len;
    bit          drained;
    drained = 1'b0;

    rst_ni          = 1'b0;
    req_ch.valid    <= 1'b0;
    req_ch.kind     <= REQ_KEY;
    req_ch.value    <= '0;
    req_ch.key_last <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Before any key the table is all zeros, so data must pass unchanged;
    // key_last on a data request is ignored.
    send_request(REQ_DATA, 8'h00, 1'b0);
    send_request(REQ_DATA, 8'hFF, 1'b1);
    send_request(REQ_DATA, 8'h5A, 1'b0);
    // A one-byte all-zero key.
    send_request(REQ_KEY, 8'h00, 1'b1);
    send_request(REQ_DATA, 8'h00, 1'b0);
    send_request(REQ_DATA, 8'hFF, 1'b0);
    // A two-byte key with the top bit set in both bytes; it starts afresh after the last.
    send_request(REQ_KEY, 8'hFF, 1'b0);
    send_request(REQ_KEY, 8'h80, 1'b1);
    send_request(REQ_DATA, 8'h01, 1'b0);
    send_request(REQ_DATA, 8'hAA, 1'b0);
    send_request(REQ_DATA, 8'h55, 1'b1);
    // The familiar "Key" / "Plain" pairing.
    send_request(REQ_KEY, 8'h4B, 1'b0);
    send_request(REQ_KEY, 8'h65, 1'b0);
    send_request(REQ_KEY, 8'h79, 1'b1);
    send_request(REQ_DATA, 8'h50, 1'b0);
    send_request(REQ_DATA, 8'h6C, 1'b0);
    send_request(REQ_DATA, 8'h61, 1'b0);
    send_request(REQ_DATA, 8'h69, 1'b0);
    send_request(REQ_DATA, 8'h6E, 1'b0);

    // Mostly whole key-then-data sequences with random content, with some
    // noise and some keys interrupted by data before they are closed.
    while (items_sent < TOTAL_ITEMS) begin
      if (!drained && items_sent >= TOTAL_ITEMS / 2) begin
        wait_for_results();
        drained = 1'b1;
      end
      case ($urandom_range(0, 19))
        0: begin
          repeat ($urandom_range(1, 4))
            send_request(req_kind_e'($urandom_range(0, 1)), 8'($urandom),
                         1'($urandom));
        end
        1: begin
          // The open key carries over into whatever key bytes come next.
          repeat ($urandom_range(1, 5)) send_request(REQ_KEY, 8'($urandom), 1'b0);
          send_data($urandom_range(1, 10));
        end
        default: begin
          case ($urandom_range(0, 39))
            0:       key_len = rc4_pkg::MAX_KEY_BYTES;
            1:       key_len = $urandom_range(rc4_pkg::MAX_KEY_BYTES + 1, 300);
            2, 3, 4: key_len = $urandom_range(17, rc4_pkg::MAX_KEY_BYTES - 1);
            default: key_len = $urandom_range(1, 16);
          endcase
          // An occasional long run can take the generator index past its wrap.
          if ($urandom_range(0, 11) == 0) data_len = $urandom_range(200, 300);
          else data_len = $urandom_range(1, 40);
          send_key(key_len);
          send_data(data_len);
        end
      endcase
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (shadow.expected_q.size() != 0)
      shadow.flag($sformatf("%0d results never arrived", shadow.expected_q.size()));

    if (shadow.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/rc4_pkg.sv
rtl/rc4_if.sv
rtl/rc4_add.sv
rtl/rc4_sbox.sv
rtl/rc4_keymem.sv
rtl/rc4_core.sv
rtl/rc4_stream_cipher.sv
sim/tb_top.sv
